// File: hw/rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue core.
// No dependencies; every other file imports this package.
package dq_pkg;

   // Operation codes carried in the request mode field
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_DUMP       = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_ELEM  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_res;
      logic               last;
   } rsp_type;

   // Classified command handed from the front end to the back end
   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
   } cmd_type;

endpackage

// File: hw/rtl/dq_front.sv
// Front end of the deque core: accepts requests and classifies them.
// Depends on dq_pkg; feeds the command queue (dq_cmd_fifo).
module dq_front
   import dq_pkg::*;
(
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_stall,
   output cmd_type cmd_data
);

   logic mode_legal;

   // Classify: only the five defined operations go on; others drop here
   always_comb begin
      mode_legal = req_data.mode inside {MODE_PUSH_FRONT, MODE_PUSH_BACK,
                                         MODE_POP_FRONT, MODE_POP_BACK, MODE_DUMP};
   end

   // Forward legal commands; hold the request while the queue is full
   assign cmd_valid      = req_valid && mode_legal;
   assign req_stall      = cmd_stall;
   assign cmd_data.op    = req_data.mode;
   assign cmd_data.value = req_data.value;

endmodule

// File: hw/rtl/dq_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on dq_pkg for the command type.
module dq_cmd_fifo
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  cmd_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output cmd_type out_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_stall  = (fill_ff == 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // Advance pointers and fill level on each transfer
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store incoming commands
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: hw/rtl/dq_back.sv
// Back end of the deque core: ring buffer state, element memory,
// dump sequencer and result register. Depends on dq_pkg.
module dq_back
   import dq_pkg::*;
#(
   parameter int CAPACITY = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_stall,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
   localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      idx_inc = (i == LAST_IDX) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
      idx_dec = (i == '0) ? LAST_IDX : i - IDX_W'(1);
   endfunction

   logic signed [31:0] store_ff [CAPACITY];
   logic signed [31:0] rd_data_ff;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic             full;
   logic             need_out;
   logic             fire;
   logic             mem_we;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [SUM_W-1:0] tail_sum;
   logic [SUM_W-1:0] tail_wrap;
   logic [IDX_W-1:0] tail_idx;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign full     = (count_ff == FULL_CNT);

   // Slot after the last element, wrapped once
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_wrap = (tail_sum >= CAP_SUM) ? tail_sum - CAP_SUM : tail_sum;
   assign tail_idx  = tail_wrap[IDX_W-1:0];

   // Hold a command that must emit a result until the result register frees up
   always_comb begin
      need_out = 1'b0;
      if (cmd_valid) begin
         case (cmd_data.op)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: need_out = full;
            MODE_DUMP:                       need_out = (count_ff == '0);
            default:                         need_out = 1'b0;
         endcase
      end
   end

   assign cmd_stall = (state_ff != ST_IDLE) || (need_out && !out_free);
   assign fire      = cmd_valid && !cmd_stall;

   // Execute commands and step the dump sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      mem_we       = 1'b0;
      wr_addr      = tail_idx;
      rd_en        = 1'b0;
      rd_addr      = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               case (cmd_data.op)
                  MODE_PUSH_FRONT: begin
                     if (full) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{status: STATUS_FULL, value_res: '0, last: 1'b1};
                     end else begin
                        mem_we   = 1'b1;
                        wr_addr  = idx_dec(head_ff);
                        head_in  = idx_dec(head_ff);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_PUSH_BACK: begin
                     if (full) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{status: STATUS_FULL, value_res: '0, last: 1'b1};
                     end else begin
                        mem_we   = 1'b1;
                        wr_addr  = tail_idx;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (count_ff != '0) begin
                        head_in  = idx_inc(head_ff);
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  MODE_POP_BACK: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  MODE_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{status: STATUS_EMPTY, value_res: '0, last: 1'b1};
                     end else begin
                        // Prefetch the front element and start the walk
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        pos_in   = idx_inc(head_ff);
                        left_in  = count_ff;
                        state_in = ST_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DUMP: begin
            // One element per transfer; fetch the next one alongside
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_ELEM, value_res: rd_data_ff,
                                last: (left_ff == CNT_W'(1))};
               left_in      = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff;
                  pos_in  = idx_inc(pos_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Element memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[wr_addr] <= cmd_data.value;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/double_ended_queue_core.sv
// Channel  Direction  Payload   Transfer when
// req_     in         req_type  req_valid high and req_stall low
// rsp_     out        rsp_type  rsp_valid high and rsp_stall low
//
// Push and pop commands finish in the back end as they are taken. A dump
// first fetches the front element and then emits one element per cycle
// while the result side takes them. The element memory's read port is
// single and registered, hence the prefetch. Reset empties the queue at
// once, with no clearing pass. A two-entry command queue lets the request
// side keep transferring while the result side stalls, until that queue fills.
// Top level of the deque core; depends on dq_pkg, dq_front, dq_cmd_fifo, dq_back.
module double_ended_queue_core
   import dq_pkg::*;
#(
   parameter int CAPACITY = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    front_valid, front_stall;
   cmd_type front_cmd;
   logic    back_valid, back_stall;
   cmd_type back_cmd;

   dq_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_stall (front_stall),
      .cmd_data  (front_cmd)
   );

   dq_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_cmd),
      .out_valid (back_valid),
      .out_stall (back_stall),
      .out_data  (back_cmd)
   );

   dq_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_stall (back_stall),
      .cmd_data  (back_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/dq_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the double-ended queue core. It follows the queue contents from
// request transfers and checks each result transfer in order.
// Depends on dq_pkg for the payload structs and the mode and status codes.
module dq_checker
   import dq_pkg::*;
#(
   parameter int CAPACITY = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      results_owed
);

   // Shadow copy of the ring buffer
   logic signed [31:0] shadow_elems [CAPACITY];
   int                 shadow_front = 0;
   int                 shadow_count = 0;

   // Results predicted but not yet seen, oldest first
   rsp_type            owed_results [$];
   int                 bad_results = 0;

   function automatic rsp_type make_result(input logic [1:0]         status,
                                           input logic signed [31:0] value,
                                           input logic               last);
      rsp_type r;
      r.status    = status;
      r.value_res = value;
      r.last      = last;
      return r;
   endfunction

   // Advance the shadow queue by one request and queue the results it owes
   task automatic apply_deque_op(input req_type item);
      int slot;
      case (item.mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (shadow_count >= CAPACITY) begin
               // drop the element, report full
               owed_results.push_back(make_result(STATUS_FULL, '0, 1'b1));
            end else if (item.mode == MODE_PUSH_FRONT) begin
               shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
               shadow_elems[shadow_front] = item.value;
               shadow_count++;
            end else begin
               slot = (shadow_front + shadow_count) % CAPACITY;
               shadow_elems[slot] = item.value;
               shadow_count++;
            end
         end
         MODE_POP_FRONT: begin
            if (shadow_count != 0) begin
               shadow_front = (shadow_front + 1) % CAPACITY;
               shadow_count--;
            end
         end
         MODE_POP_BACK: begin
            if (shadow_count != 0) shadow_count--;
         end
         MODE_DUMP: begin
            if (shadow_count == 0) begin
               owed_results.push_back(make_result(STATUS_EMPTY, '0, 1'b1));
            end else begin
               // emit front to back, mark the final element
               for (int i = 0; i < shadow_count; i++) begin
                  slot = (shadow_front + i) % CAPACITY;
                  owed_results.push_back(make_result(STATUS_ELEM, shadow_elems[slot],
                                                     i == shadow_count - 1));
               end
            end
         end
         default: begin
            // unused modes leave the queue alone
         end
      endcase
   endtask

   // Compare one result transfer against the oldest prediction
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (owed_results.size() == 0) begin
         bad_results++;
         if (bad_results <= 10)
            $display("[%0t] unexpected result: status=%0d value=%0d last=%0b",
                     $realtime, got.status, got.value_res, got.last);
      end else begin
         want = owed_results.pop_front();
         if (got.status !== want.status || got.value_res !== want.value_res ||
             got.last !== want.last) begin
            bad_results++;
            if (bad_results <= 10)
               $display("[%0t] want st=%0d val=%0d last=%0b, got st=%0d val=%0d last=%0b",
                        $realtime, want.status, want.value_res, want.last,
                        got.status, got.value_res, got.last);
         end
      end
   endtask

   // Requests first, so a result of the same edge always finds its prediction
   always @(posedge clock) begin
      if (reset) begin
         shadow_front = 0;
         shadow_count = 0;
         owed_results.delete();
      end else begin
         if (req_valid && !req_stall) apply_deque_op(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      mismatch_count <= bad_results;
      results_owed   <= owed_results.size();
   end

endmodule

// File: bench/double_ended_queue_core_tb.sv
`timescale 1ns / 1ps
// Top of the double-ended queue bench: clock, reset, request stimulus, result stall
// and the verdict. Depends on dq_pkg, double_ended_queue_core and dq_checker.
module double_ended_queue_core_tb;
   import dq_pkg::*;

   localparam int CAPACITY       = 32;
   localparam int ITEM_TARGET    = 450;
   localparam int IDLE_PCT       = 38;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;

   logic    clock         = 1'b0;
   logic    reset         = 1'b1;
   logic    req_valid     = 1'b0;
   logic    req_stall;
   req_type req_data      = '0;
   logic    rsp_valid;
   logic    rsp_stall     = 1'b0;
   rsp_type rsp_data;
   logic    quiet_stretch = 1'b0;
   int      mismatch_count;
   int      results_owed;
   int      stuck_cycles  = 0;

   double_ended_queue_core #(
      .CAPACITY (CAPACITY)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   dq_checker #(
      .CAPACITY (CAPACITY)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the result side at random, except during the quiet stretch
   always @(posedge clock) begin
      if (quiet_stretch) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < IDLE_PCT);
   end

   // Abort when no transfer happens on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Present one request, with random idle cycles ahead of it outside the
   // quiet stretch, and hold it until the transfer
   task automatic send_request(input logic [2:0] mode, input logic signed [31:0] value);
      req_type item;
      item.mode  = mode;
      item.value = value;
      while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off requests until every predicted result has been seen
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   initial begin
      int          sent;
      int          phase_left;
      int          pick;
      logic        filling;
      logic        paused;
      logic [2:0]  mode;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue cases, ignored modes, value extremes, index wrap
      send_request(MODE_DUMP, $urandom());
      send_request(MODE_POP_FRONT, $urandom());
      send_request(MODE_POP_BACK, $urandom());
      send_request(3'd5, $urandom());
      send_request(3'd6, $urandom());
      send_request(3'd7, $urandom());
      send_request(MODE_DUMP, $urandom());
      send_request(MODE_PUSH_BACK, 32'sh7fffffff);
      send_request(MODE_PUSH_FRONT, 32'sh80000000);
      send_request(MODE_PUSH_BACK, 32'sh00000000);
      send_request(MODE_PUSH_FRONT, 32'shffffffff);
      send_request(MODE_PUSH_BACK, 32'sh00000001);
      send_request(MODE_DUMP, $urandom());
      send_request(MODE_POP_FRONT, $urandom());
      send_request(MODE_DUMP, $urandom());
      send_request(MODE_POP_BACK, $urandom());
      send_request(MODE_DUMP, $urandom());
      send_request(MODE_PUSH_FRONT, 32'sh55555555);
      send_request(MODE_PUSH_BACK, 32'shaaaaaaaa);
      send_request(MODE_DUMP, $urandom());
      drain_results();

      // Random: alternate fill and drain phases so the queue swings between
      // empty and full, with dumps throughout and some unused modes mixed in
      sent       = 0;
      filling    = 1'b1;
      paused     = 1'b0;
      phase_left = 50;
      while (sent < ITEM_TARGET) begin
         if (sent == 150 && !quiet_stretch) quiet_stretch <= 1'b1;
         if (sent == 260 && quiet_stretch) quiet_stretch <= 1'b0;
         if (sent == 320 && !paused) begin
            drain_results();
            paused = 1'b1;
         end
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(30, 70);
         end
         phase_left--;

         pick = $urandom_range(99);
         if (filling) begin
            if (pick < 40)      mode = MODE_PUSH_FRONT;
            else if (pick < 80) mode = MODE_PUSH_BACK;
            else if (pick < 85) mode = MODE_POP_FRONT;
            else if (pick < 89) mode = MODE_POP_BACK;
            else if (pick < 96) mode = MODE_DUMP;
            else                mode = 3'($urandom_range(5, 7));
         end else begin
            if (pick < 10)      mode = MODE_PUSH_FRONT;
            else if (pick < 20) mode = MODE_PUSH_BACK;
            else if (pick < 50) mode = MODE_POP_FRONT;
            else if (pick < 80) mode = MODE_POP_BACK;
            else if (pick < 95) mode = MODE_DUMP;
            else                mode = 3'($urandom_range(5, 7));
         end

         send_request(mode, $urandom());
         if (mode <= MODE_DUMP) sent++;
      end

      // Let the last results arrive, then watch for strays
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && results_owed == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
